FILE: hdl/iterated_aitken_accelerator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the iterated Aitken accelerator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ITERATED_AITKEN_ACCELERATOR_DEFINES_SVH
`define ITERATED_AITKEN_ACCELERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define IAA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IAA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IAA_ASSERT_IMP(lbl, ante, cons, msg)
`define IAA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/iaa_pkg.sv
// ----------------------------------------------------------------------------
// iaa_pkg
// Shared types and constants of the iterated Aitken accelerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package iaa_pkg;
  localparam int unsigned MAX_LEVELS  = 15;
  localparam int unsigned STORE_DEPTH = 2 * MAX_LEVELS + 1;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LV_W        = 4;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned NUM_W       = 2 * DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_W);

  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [DATA_W-1:0] word_t;

  // response of the shared Aitken step unit
  typedef struct packed {
    logic  done;
    logic  zero_div;
    word_t res;
  } step_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/iaa_cell.sv
// ----------------------------------------------------------------------------
// iaa_cell
// One term of the row; shifts toward cell 0, tail cell takes the insert word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iaa_cell (
  input  wire                 clk_i,
  input  wire                 shift_i,
  input  wire                 tail_i,
  input  wire iaa_pkg::word_t ins_i,
  input  wire iaa_pkg::word_t nxt_i,
  output iaa_pkg::word_t      val_o
);
  import iaa_pkg::*;

  word_t val_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= tail_i ? ins_i : nxt_i;
    end
  end

  assign val_o = val_q;
endmodule
`default_nettype wire

FILE: hdl/iaa_step.sv
// ----------------------------------------------------------------------------
// iaa_step
// One Aitken step: squared numerator from half-word products, then a restoring divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iaa_step (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire iaa_pkg::word_t x0_i,
  input  wire iaa_pkg::word_t x1_i,
  input  wire iaa_pkg::word_t x2_i,
  output iaa_pkg::step_rsp_t  rsp_o
);
  import iaa_pkg::*;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_DIV  = 5'b00100,
    U_FIN  = 5'b01000,
    U_DONE = 5'b10000
  } ustate_e;

  ustate_e                state_q, state_d;
  word_t                  s_q, u2_q, res_q, prod_q;
  logic [DATA_W:0]        den_q;
  logic                   neg_q, zd_q;
  logic [1:0]             ph_q;
  logic [NUM_W-1:0]       num_q;
  logic [DATA_W:0]        rem_q;
  logic [DIV_CNT_W-1:0]   bit_q;

  // setup
  word_t           u0, u1, u2, s;
  logic [DATA_W:0] p, q;
  always_comb begin
    u0 = x0_i ^ SIGN_BIT;
    u1 = x1_i ^ SIGN_BIT;
    u2 = x2_i ^ SIGN_BIT;
    s  = (u2 >= u1) ? u2 - u1 : u1 - u2;
    p  = {1'b0, u2} + {1'b0, u0};
    q  = {u1, 1'b0};
  end

  // multiplier half-words
  logic [DATA_W/2-1:0] mul_a, mul_b;
  word_t               prod_d;
  logic [NUM_W-1:0]    addend;
  always_comb begin
    mul_a  = ph_q[1] ? s_q[DATA_W-1:DATA_W/2] : s_q[DATA_W/2-1:0];
    mul_b  = (ph_q == 2'd0) ? s_q[DATA_W/2-1:0] : s_q[DATA_W-1:DATA_W/2];
    prod_d = DATA_W'(mul_a) * DATA_W'(mul_b);
    unique case (ph_q)
      2'd1:    addend = {{DATA_W{1'b0}}, prod_q};
      2'd2:    addend = {{(DATA_W/2-1){1'b0}}, prod_q, {(DATA_W/2+1){1'b0}}};
      2'd3:    addend = {prod_q, {DATA_W{1'b0}}};
      default: addend = '0;
    endcase
  end

  // divide step
  logic [DATA_W+1:0] trial, den_ext;
  logic              ge;
  always_comb begin
    trial   = {rem_q, num_q[NUM_W-1]};
    den_ext = {1'b0, den_q};
    ge      = trial >= den_ext;
  end

  // final correction with saturation
  word_t ql, fin_res;
  logic  qh_nz;
  always_comb begin
    ql    = num_q[DATA_W-1:0];
    qh_nz = |num_q[NUM_W-1:DATA_W];
    if (!neg_q) begin
      fin_res = (qh_nz || ql > u2_q) ? SIGN_BIT : (u2_q - ql) ^ SIGN_BIT;
    end else begin
      fin_res = (qh_nz || ql > ~u2_q) ? ~SIGN_BIT : (u2_q + ql) ^ SIGN_BIT;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (start_i) state_d = (p == q) ? U_DONE : U_MUL;
      U_MUL:  if (ph_q == 2'd3) state_d = U_DIV;
      U_DIV:  if (bit_q == DIV_CNT_W'(NUM_W - 1)) state_d = U_FIN;
      U_FIN:  state_d = U_DONE;
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        s_q   <= s;
        u2_q  <= u2;
        neg_q <= p < q;
        den_q <= (p < q) ? q - p : p - q;
        ph_q  <= 2'd0;
        num_q <= '0;
        res_q <= x2_i;
        zd_q  <= 1'b1;
      end
      U_MUL: begin
        prod_q <= prod_d;
        num_q  <= num_q + addend;
        ph_q   <= ph_q + 2'd1;
        rem_q  <= '0;
        bit_q  <= '0;
      end
      U_DIV: begin
        rem_q <= ge ? (DATA_W + 1)'(trial - den_ext) : trial[DATA_W:0];
        num_q <= {num_q[NUM_W-2:0], ge};
        bit_q <= bit_q + 1'b1;
      end
      U_FIN: begin
        res_q <= fin_res;
        zd_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_o.done     = (state_q == U_DONE);
  assign rsp_o.zero_div = zd_q;
  assign rsp_o.res      = res_q;
endmodule
`default_nettype wire

FILE: hdl/iterated_aitken_accelerator.sv
// ----------------------------------------------------------------------------
// iterated_aitken_accelerator
// Iterated Aitken delta-squared limit estimate over a row of term cells.
// ----------------------------------------------------------------------------
// Usage:
//  - APB register 0 (addr 0x0): levels, 4 bits, reset 1. Write only while idle;
//    a write drops any partial load and clears the zero-divide flag.
//  - Input stream: one Q32.32 sample per word. A run is 2*levels+1 words
//    (2 words when levels is 0). s_axis_tready_o is high while loading.
//  - Output stream: one word per run, tdata = limit, tuser = zero_divide.
//  - Sequence: a load accepts one word per cycle while tvalid is high. Then
//    levels^2 Aitken steps run on one shared unit, each through start, multiply,
//    divide, final correction and done; a zero-denominator step goes from start
//    straight to done. Each pass ends by shifting its two leftover terms out of
//    the row, then the emit registers the limit; levels = 0 goes straight to it.
//  - The term row shifts toward cell 0; each step result enters at the tail
//    of the current length, so a pass rewrites the row in place.
//  - A finished word sits in the output register; a new run is accepted
//    meanwhile and the block only waits if a second result is ready first.
//  - Reset clears the control state; the term row holds no reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "iterated_aitken_accelerator_defines.svh"
module iterated_aitken_accelerator (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // input stream; tdata: [63:0] sample
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire  [63:0]            s_axis_tdata_i,
  // output stream; tdata: [63:0] limit; tuser: [0] zero_divide
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  output logic [63:0]            m_axis_tdata_o,
  output logic [0:0]             m_axis_tuser_o,
  // configuration
  input  wire                    psel_i,
  input  wire                    penable_i,
  input  wire                    pwrite_i,
  input  wire  [2:0]             paddr_i,
  input  wire  [31:0]            pwdata_i,
  output logic [31:0]            prdata_o,
  output logic                   pready_o
);
  import iaa_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DROP  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e           state_q;
  logic [LV_W-1:0]  levels_q;
  logic [CNT_W-1:0] cnt_q, len_q, step_q;
  logic             drop_q, flag_q;
  logic             m_valid_q;
  word_t            m_data_q;
  logic             m_user_q;

  // config port
  logic cfg_we;
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && !paddr_i[2];
  assign prdata_o = paddr_i[2] ? 32'd0 : {{(32-LV_W){1'b0}}, levels_q};

  // run length
  logic [LV_W-1:0]  lv;
  logic [CNT_W-1:0] need;
  logic             lv_zero;
  always_comb begin
    lv      = (levels_q > LV_W'(MAX_LEVELS)) ? LV_W'(MAX_LEVELS) : levels_q;
    lv_zero = (lv == '0);
    need    = lv_zero ? CNT_W'(2) : CNT_W'({lv, 1'b1});
  end

  logic s_fire;
  assign s_axis_tready_o = (state_q == S_LOAD);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Aitken unit
  word_t     cell_val [STORE_DEPTH];
  step_rsp_t rsp;
  logic      step_start;
  assign step_start = (state_q == S_START);

  iaa_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (step_start),
    .x0_i    (cell_val[0]),
    .x1_i    (cell_val[1]),
    .x2_i    (cell_val[2]),
    .rsp_o   (rsp)
  );

  // row of term cells
  logic             shift_en;
  logic [CNT_W-1:0] tail;
  word_t            ins;
  word_t            cell_nxt [STORE_DEPTH];
  always_comb begin
    shift_en = s_fire || (state_q == S_WAIT && rsp.done) || (state_q == S_DROP);
    tail     = (state_q == S_LOAD) ? need - 1'b1 : len_q - 1'b1;
    ins      = (state_q == S_LOAD) ? s_axis_tdata_i : rsp.res;
    for (int k = 0; k < STORE_DEPTH - 1; k++) begin
      cell_nxt[k] = cell_val[k+1];
    end
    cell_nxt[STORE_DEPTH-1] = ins;
  end

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    iaa_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .tail_i  (tail == CNT_W'(k)),
      .ins_i   (ins),
      .nxt_i   (cell_nxt[k]),
      .val_o   (cell_val[k])
    );
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      levels_q  <= LV_W'(1);
      cnt_q     <= '0;
      len_q     <= '0;
      step_q    <= '0;
      drop_q    <= 1'b0;
      flag_q    <= 1'b0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        levels_q <= pwdata_i[LV_W-1:0];
        cnt_q    <= '0;
        flag_q   <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (s_fire) begin
            if (cnt_q == need - 1'b1) begin
              cnt_q  <= '0;
              len_q  <= need;
              step_q <= '0;
              state_q <= lv_zero ? S_EMIT : S_START;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            if (rsp.zero_div) flag_q <= 1'b1;
            step_q <= step_q + 1'b1;
            if (step_q + 1'b1 == len_q - CNT_W'(2)) begin
              drop_q  <= 1'b0;
              state_q <= S_DROP;
            end else begin
              state_q <= S_START;
            end
          end
        end
        S_DROP: begin
          drop_q <= 1'b1;
          if (drop_q) begin
            len_q  <= len_q - CNT_W'(2);
            step_q <= '0;
            state_q <= (len_q == CNT_W'(3)) ? S_EMIT : S_START;
          end
        end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= lv_zero ? cell_val[1] : cell_val[0];
            m_user_q  <= lv_zero ? 1'b0 : flag_q;
            flag_q    <= 1'b0;
            state_q   <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_user_q;

  `IAA_ASSERT_IMP(a_load_cnt, state_q == S_LOAD, cnt_q < need, "load count past run length")
  `IAA_ASSERT_IMP(a_len_odd, state_q == S_START, len_q[0] && len_q >= CNT_W'(3),
                  "bad row length at step start")
  `IAA_ASSERT_IMP(a_done_wait, rsp.done, state_q == S_WAIT, "step done outside wait")
  `IAA_ASSERT_NXT(a_emit_out, state_q == S_EMIT && (!m_valid_q || m_axis_tready_i),
                  m_valid_q && state_q == S_LOAD, "result not registered")
endmodule
`default_nettype wire

FILE: test/tb_iterated_aitken_accelerator.sv
// ----------------------------------------------------------------------------
// tb_iterated_aitken_accelerator
// Self-checking bench: streams sequence terms through the accelerator under
// several levels settings, predicts each limit word, compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_iterated_aitken_accelerator;
  import iaa_pkg::*;

  localparam logic [2:0] REG_LEVELS = 3'd0;
  localparam int         LIMIT_CYC  = 2000000;
  localparam int         RAND_ITEMS = 50;   // per random phase

  typedef struct {
    word_t limit;
    bit    zd;
  } limit_exp_t;

  // Predictor of the accelerator plus the queue of pending limit words.
  class limit_scoreboard;
    word_t      terms [STORE_DEPTH];
    int         load_cnt;
    bit         div_flag;
    int         lv;
    limit_exp_t pending_q[$];
    int         errors;

    function new();
      lv = 1;
    endfunction

    function void configure(int value);
      lv       = value & 15;
      load_cnt = 0;
      div_flag = 0;
    endfunction

    // one delta-squared step on c - d21^2/(d21+d01), saturated
    function word_t aitken(word_t a, word_t b, word_t c);
      logic signed [67:0]  d21, d01, den;
      logic        [67:0]  abs_den, abs_d21;
      logic        [127:0] num, quo;
      logic signed [131:0] r;
      d21 = $signed({{4{c[63]}}, c}) - $signed({{4{b[63]}}, b});
      d01 = $signed({{4{a[63]}}, a}) - $signed({{4{b[63]}}, b});
      den = d21 + d01;
      if (den == 0) begin
        div_flag = 1;
        return c;
      end
      abs_den = (den < 0) ? -den : den;
      abs_d21 = (d21 < 0) ? -d21 : d21;
      num = {64'b0, abs_d21[63:0]} * {64'b0, abs_d21[63:0]};
      quo = num / {60'b0, abs_den};
      if (den < 0) r = $signed({{68{c[63]}}, c}) + $signed({4'b0, quo});
      else         r = $signed({{68{c[63]}}, c}) - $signed({4'b0, quo});
      if (r > $signed(132'sh7FFF_FFFF_FFFF_FFFF)) return {1'b0, {63{1'b1}}};
      if (r < -$signed(132'sh8000_0000_0000_0000)) return SIGN_BIT;
      return r[63:0];
    endfunction

    // accepted sample word
    function void note_sample(word_t v);
      int need;
      limit_exp_t e;
      need = (lv == 0) ? 2 : 2 * lv + 1;
      if (load_cnt >= need) load_cnt = 0;
      terms[load_cnt] = v;
      load_cnt++;
      if (load_cnt < need) return;
      if (lv == 0) begin
        e.limit  = terms[1];
        div_flag = 0;
      end else begin
        for (int p = 1; p <= lv; p++)
          for (int i = 0; i <= 2 * (lv - p); i++)
            terms[i] = aitken(terms[i], terms[i+1], terms[i+2]);
        e.limit = terms[0];
      end
      e.zd = div_flag;
      pending_q.push_back(e);
      load_cnt = 0;
      div_flag = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_limit(word_t data, bit user);
      limit_exp_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected limit word %h", data));
        return;
      end
      e = pending_q.pop_front();
      if (data !== e.limit)
        report($sformatf("limit %h, predicted %h", data, e.limit));
      if (user !== e.zd)
        report($sformatf("zero_divide %b, predicted %b", user, e.zd));
    endtask
  endclass

  logic        clk, rst_n;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  limit_scoreboard sb = new();
  int cycles;

  iterated_aitken_accelerator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [63:0] sample
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [63:0] limit
    .m_axis_tuser_o  (m_tuser),   // [0] zero_divide
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // receiver: check on handshake, stall at random; a calm stretch now and then
  initial begin : rx
    int stall;
    m_tready = 1;
    stall    = 0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) sb.check_limit(m_tdata, m_tuser[0]);
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if ($urandom_range(0, 9) < 3) stall = gap_len();
      end
    end
  end

  // one sample word; a word is taken at the edge where tvalid and tready meet
  task send_sample(word_t v);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
  endtask

  task end_burst();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // setup then access cycle; pready is tied high
  task apb_write_levels(int value);
    end_burst();
    wait_drained();
    repeat (20) @(posedge clk);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= REG_LEVELS;
    pwdata  <= {16'($urandom_range(0, 'hFFFF)), 12'h0, 4'(value)};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    sb.configure(value);
    @(posedge clk);
  endtask

  // one run of terms: convergent, wild or tiny (tiny makes zero denominators)
  task send_run(int n);
    int    kind, sh;
    word_t base, delta;
    kind  = $urandom_range(0, 9);
    sh    = $urandom_range(0, 40);
    base  = {$urandom, $urandom};
    base  = $signed(base) >>> $urandom_range(0, 30);
    delta = {$urandom, $urandom};
    delta = $signed(delta) >>> sh;
    for (int k = 0; k < n; k++) begin
      if (kind < 7)
        send_sample(base + ((k[0] && kind < 3) ? -($signed(delta) >>> k)
                                               : ($signed(delta) >>> k)));
      else if (kind < 9)
        send_sample({$urandom, $urandom});
      else
        send_sample(64'($signed($urandom_range(0, 2)) - 1));
    end
  endtask

  task random_phase(int lv, int items, bit drain_mid);
    int sent, need;
    need = (lv == 0) ? 2 : 2 * lv + 1;
    sent = 0;
    apb_write_levels(lv);
    while (sent < items) begin
      if (drain_mid && sent >= items / 2) begin
        // sender holds off until every pending limit word is out
        end_burst();
        wait_drained();
        drain_mid = 0;
      end
      // a broken run now and then: cut short, left for the next run to absorb
      if ($urandom_range(0, 19) == 0) begin
        send_sample({$urandom, $urandom});
        sent++;
      end
      send_run(need);
      sent += need;
    end
  endtask

  initial begin : main
    s_tvalid = 0;
    s_tdata  = 0;
    psel     = 0;
    penable  = 0;
    pwrite   = 0;
    paddr    = 0;
    pwdata   = 0;
    cycles   = 0;
    rst_n    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, reset levels of 1: extremes, saturation, zero denominators
    send_sample({1'b0, {63{1'b1}}}); send_sample(SIGN_BIT); send_sample({1'b0, {63{1'b1}}});
    send_sample(SIGN_BIT); send_sample({1'b0, {63{1'b1}}}); send_sample(SIGN_BIT);
    send_sample(64'd5); send_sample(64'd5); send_sample(64'd5);
    send_sample(64'h1_0000_0000); send_sample(64'h2_0000_0000);
    send_sample(64'h3_0000_0000);
    send_sample(64'h0); send_sample({1'b0, {63{1'b1}}}); send_sample(64'h0);
    send_sample(SIGN_BIT); send_sample(64'h0); send_sample(64'h1);
    send_sample('1); send_sample('1); send_sample(64'h1);
    // partial load, dropped by the next write
    send_sample(64'h7);
    apb_write_levels(0);
    send_sample(SIGN_BIT); send_sample({1'b0, {63{1'b1}}});
    send_sample(64'h1234); send_sample('1);

    random_phase(15, 62, 0);
    random_phase(1, RAND_ITEMS, 1);
    random_phase(0, RAND_ITEMS, 0);
    random_phase(2, RAND_ITEMS, 0);
    random_phase(3, RAND_ITEMS, 0);
    random_phase(1, RAND_ITEMS, 0);
    random_phase(4, RAND_ITEMS, 0);
    random_phase(2, RAND_ITEMS, 0);
    random_phase(0, RAND_ITEMS, 0);
    random_phase(5, 33, 0);
    random_phase(1, RAND_ITEMS, 0);
    random_phase(3, RAND_ITEMS, 0);

    end_burst();
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: iterated_aitken_accelerator.f
+incdir+hdl
hdl/iaa_pkg.sv
hdl/iaa_cell.sv
hdl/iaa_step.sv
hdl/iterated_aitken_accelerator.sv
test/tb_iterated_aitken_accelerator.sv
